FILE: rtl/hex_escape_to_unicode_stream_macros.svh
// Assertion macros used by the bound checker heu_checker.
`ifndef HEX_ESCAPE_TO_UNICODE_STREAM_MACROS_SVH
`define HEX_ESCAPE_TO_UNICODE_STREAM_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define HEU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heu check failed");

// Implication into the next cycle, off while reset is asserted.
`define HEU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heu check failed");

// Implication that is also checked while reset is asserted.
`define HEU_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("heu check failed");

`endif

FILE: rtl/heu_pkg.sv
package heu_pkg;

    localparam int UNIT_W    = 16;
    localparam int WIN_CELLS = 5;

    localparam logic [UNIT_W-1:0] CHAR_BSLASH  = 16'h005C;
    localparam logic [UNIT_W-1:0] CHAR_UPPER_U = 16'h0055;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_U = 16'h0075;
    localparam logic [UNIT_W-1:0] CHAR_PLUS    = 16'h002B;

    // One window cell: held unit, occupancy and end-of-region mark.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              valid;
        logic              tag;
    } cell_t;

    // One result beat.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              decoded;
        logic              last;
    } result_t;

    // {ok, nibble}: ok is set for 0-9, A-F, a-f.
    function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] c);
        logic [UNIT_W-1:0] d;
        logic              ok;
        d  = '0;
        ok = 1'b0;
        if (c >= 16'h0030 && c <= 16'h0039)
        begin
            d  = c - 16'h0030;
            ok = 1'b1;
        end
        else if (c >= 16'h0041 && c <= 16'h0046)
        begin
            d  = c - 16'h0037;
            ok = 1'b1;
        end
        else if (c >= 16'h0061 && c <= 16'h0066)
        begin
            d  = c - 16'h0057;
            ok = 1'b1;
        end
        return {ok, d[3:0]};
    endfunction

    function automatic logic is_u_letter(input logic [UNIT_W-1:0] c);
        return (c == CHAR_UPPER_U) || (c == CHAR_LOWER_U);
    endfunction

endpackage

FILE: rtl/heu_cell.sv
// One window cell: loads its right neighbor on shift, empties on clear.
module heu_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic            clr,
    input  heu_pkg::cell_t  nbr,
    output heu_pkg::cell_t  cur
);

    logic [heu_pkg::UNIT_W-1:0] unit_reg;
    logic [heu_pkg::UNIT_W-1:0] unit_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       tag_reg;
    logic                       tag_next;

    always_comb
    begin
        unit_next  = unit_reg;
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (clr)
        begin
            valid_next = 1'b0;
            tag_next   = 1'b0;
        end
        else if (shift_en)
        begin
            unit_next  = nbr.unit;
            valid_next = nbr.valid;
            tag_next   = nbr.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign cur.unit  = unit_reg;
    assign cur.valid = valid_reg;
    assign cur.tag   = tag_reg;

endmodule

FILE: rtl/heu_match.sv
// Escape detector over five held units plus the incoming one.
module heu_match
(
    input  heu_pkg::cell_t              win [heu_pkg::WIN_CELLS],
    input  logic [heu_pkg::UNIT_W-1:0]  code_unit,
    output logic                        hit,
    output logic [heu_pkg::UNIT_W-1:0]  value
);

    logic       prefix_ok;
    logic [4:0] d2;
    logic [4:0] d3;
    logic [4:0] d4;
    logic [4:0] d5;

    always_comb
    begin
        prefix_ok = (heu_pkg::is_u_letter(win[0].unit) && win[1].unit == heu_pkg::CHAR_PLUS)
                 || (win[0].unit == heu_pkg::CHAR_BSLASH && heu_pkg::is_u_letter(win[1].unit));
        d2 = heu_pkg::hex_digit(win[2].unit);
        d3 = heu_pkg::hex_digit(win[3].unit);
        d4 = heu_pkg::hex_digit(win[4].unit);
        d5 = heu_pkg::hex_digit(code_unit);
        // window must be full: valid bits are packed toward the newest cell
        hit   = win[0].valid && prefix_ok && d2[4] && d3[4] && d4[4] && d5[4];
        value = {d2[3:0], d3[3:0], d4[3:0], d5[3:0]};
    end

endmodule

FILE: rtl/heu_outq.sv
// Two-entry result queue between the cell chain and the output port.
module heu_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  heu_pkg::result_t  push_item,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output heu_pkg::result_t  head
);

    heu_pkg::result_t slot_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/hex_escape_to_unicode_stream.sv
// Hex escape decoder for a UTF-16 stream. Code units enter one per beat; the
// block holds the five units before the current one in a chain of five cells
// and replaces any six-unit U+hhhh, u+hhhh, \uhhhh or \Uhhhh (hex digits in
// either case) by one unit with is_decoded set, matching leftmost with no
// overlap. Units that are not part of an escape leave unchanged and in order.
// Rate: one unit per clock while the output keeps up and no flush runs; a
// match or a pass-through unit does not hold up the input. A last_unit beat
// that does not complete an escape starts a flush: the chain shifts out one
// cell per clock while the queue has room, emitting every held unit, the last
// with last_out set; in_stall is high while the flush runs. Results go via a
// two-entry queue, so an input beat is still taken while one result waits.
module hex_escape_to_unicode_stream
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [heu_pkg::UNIT_W-1:0]  code_unit,
    input  logic                        last_unit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [heu_pkg::UNIT_W-1:0]  out_unit,
    output logic                        is_decoded,
    output logic                        last_out
);

    // chain_link[i] is the content of cell i (0 = oldest); the extra top
    // entry is what the newest cell loads on a shift.
    heu_pkg::cell_t             chain_link [heu_pkg::WIN_CELLS+1];
    heu_pkg::cell_t             win        [heu_pkg::WIN_CELLS];
    heu_pkg::result_t           push_item;
    heu_pkg::result_t           head;

    logic                       accept;
    logic                       hit;
    logic                       take_hit;
    logic [heu_pkg::UNIT_W-1:0] hit_value;
    logic                       shift_en;
    logic                       q_full;
    logic                       push;
    logic                       flush_step;
    logic                       flush_reg;
    logic                       flush_next;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = flush_reg || q_full;
    assign flush_step = flush_reg && !q_full;
    assign take_hit   = accept && hit;

    // Normal beats shift the new unit in; flush shifts in an empty cell.
    assign shift_en = (accept && !hit) || flush_step;

    assign chain_link[heu_pkg::WIN_CELLS].unit  = code_unit;
    assign chain_link[heu_pkg::WIN_CELLS].valid = accept;
    assign chain_link[heu_pkg::WIN_CELLS].tag   = accept && last_unit;

    genvar gi;
    generate
        for (gi = 0; gi < heu_pkg::WIN_CELLS; gi++)
        begin : g_cell
            heu_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .clr      (take_hit),
                .nbr      (chain_link[gi+1]),
                .cur      (chain_link[gi])
            );
            assign win[gi] = chain_link[gi];
        end
    endgenerate

    heu_match u_match
    (
        .win       (win),
        .code_unit (code_unit),
        .hit       (hit),
        .value     (hit_value)
    );

    // Result selection: decoded unit on a match, else the unit that drops
    // out of the oldest cell. The oldest cell only carries a tag in flush.
    always_comb
    begin
        push_item = '0;
        push      = 1'b0;
        if (take_hit)
        begin
            push              = 1'b1;
            push_item.unit    = hit_value;
            push_item.decoded = 1'b1;
            push_item.last    = last_unit;
        end
        else if (shift_en && chain_link[0].valid)
        begin
            push              = 1'b1;
            push_item.unit    = chain_link[0].unit;
            push_item.decoded = 1'b0;
            push_item.last    = chain_link[0].tag;
        end
    end

    // Flush runs from an unmatched last beat until the tagged unit leaves.
    always_comb
    begin
        flush_next = flush_reg;
        if (accept && last_unit && !hit)
        begin
            flush_next = 1'b1;
        end
        else if (flush_step && chain_link[0].valid && chain_link[0].tag)
        begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg <= 1'b0;
        end
        else
        begin
            flush_reg <= flush_next;
        end
    end

    heu_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_unit   = head.unit;
    assign is_decoded = head.decoded;
    assign last_out   = head.last;

endmodule

FILE: rtl/heu_checker.sv
`include "hex_escape_to_unicode_stream_macros.svh"

module heu_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [heu_pkg::UNIT_W-1:0]  code_unit,
    input logic                        last_unit,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [heu_pkg::UNIT_W-1:0]  out_unit,
    input logic                        is_decoded,
    input logic                        last_out
);

    // stalled result holds
    `HEU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_unit) && $stable(is_decoded) && $stable(last_out))
    // no result and no stall while in reset
    `HEU_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid && !in_stall)
    // stall only rises after an input beat
    `HEU_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall))
    // a result appears only from an input beat or a flush step
    `HEU_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && !in_stall) || $past(in_stall))

endmodule

bind hex_escape_to_unicode_stream heu_checker u_heu_checker (.*);

FILE: tb/hex_escape_stream_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the hex escape decoder, predicts the result
// stream from the accepted input beats and compares it beat by beat.
module hex_escape_stream_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [heu_pkg::UNIT_W-1:0]  code_unit,
    input  logic                        last_unit,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [heu_pkg::UNIT_W-1:0]  out_unit,
    input  logic                        is_decoded,
    input  logic                        last_out,
    output int                          fail_count,
    output int                          waiting_results,
    output int                          units_in,
    output int                          units_out,
    output int                          decoded_out
);

    // Units held back while they could still start an escape.
    logic [4:0][15:0]        held_units;
    int                      held_count;
    heu_pkg::result_t        expected_units[$];

    // Nibble value of a hex digit in either case, -1 for anything else.
    function automatic int nibble_of(input logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039)
            return int'(c) - 'h30;
        if (c >= 16'h0041 && c <= 16'h0046)
            return int'(c) - 'h41 + 10;
        if (c >= 16'h0061 && c <= 16'h0066)
            return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    function automatic logic u_letter(input logic [15:0] c);
        return (c == heu_pkg::CHAR_UPPER_U) || (c == heu_pkg::CHAR_LOWER_U);
    endfunction

    // Six units oldest first; returns 1 and the code point on an escape.
    function automatic logic escape_value(input logic [5:0][15:0] s,
                                          output logic [15:0] val);
        logic ok;
        int   d;
        int   k;
        ok  = (u_letter(s[0]) && s[1] == heu_pkg::CHAR_PLUS) ||
              (s[0] == heu_pkg::CHAR_BSLASH && u_letter(s[1]));
        val = '0;
        for (k = 2; k < 6; k++)
        begin
            d = nibble_of(s[k]);
            if (d < 0)
                ok = 1'b0;
            else
                val = {val[11:0], d[3:0]};
        end
        return ok;
    endfunction

    function automatic heu_pkg::result_t make_result(input logic [15:0] u,
                                                     input logic dec,
                                                     input logic lst);
        heu_pkg::result_t r;
        r.unit    = u;
        r.decoded = dec;
        r.last    = lst;
        return r;
    endfunction

    // Advance the window by one accepted unit and queue what it releases.
    task automatic decode_next_unit(input logic [15:0] cu, input logic lu);
        logic [5:0][15:0] seq;
        logic [15:0]      val;
        int               n;
        int               i;
        for (i = 0; i < held_count; i++)
            seq[i] = held_units[i];
        seq[held_count] = cu;
        n = held_count + 1;
        if (n == 6)
        begin
            if (escape_value(seq, val))
            begin
                expected_units.push_back(make_result(val, 1'b1, lu));
                held_count = 0;
                return;
            end
            // oldest unit can no longer start an escape
            expected_units.push_back(make_result(seq[0], 1'b0, 1'b0));
            for (i = 1; i < 6; i++)
                seq[i-1] = seq[i];
            n = 5;
        end
        if (lu)
        begin
            for (i = 0; i < n; i++)
                expected_units.push_back(make_result(seq[i], 1'b0, i == n - 1));
            held_count = 0;
        end
        else
        begin
            for (i = 0; i < n; i++)
                held_units[i] = seq[i];
            held_count = n;
        end
    endtask

    function automatic void report_field(input string name, input logic [15:0] exp_v,
                                         input logic [15:0] act_v);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        heu_pkg::result_t want;
        if (!rst_n)
        begin
            held_count      = 0;
            expected_units.delete();
            fail_count      = 0;
            waiting_results = 0;
            units_in        = 0;
            units_out       = 0;
            decoded_out     = 0;
        end
        else
        begin
            // predict first: a result beat at this edge is always older
            if (in_valid && !in_stall)
            begin
                units_in++;
                decode_next_unit(code_unit, last_unit);
            end
            if (out_valid && !out_stall)
            begin
                units_out++;
                if (is_decoded)
                    decoded_out++;
                if (expected_units.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h/%b/%b",
                             $time, out_unit, is_decoded, last_out);
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (out_unit !== want.unit)
                    begin
                        fail_count++;
                        report_field("out_unit", want.unit, out_unit);
                    end
                    if (is_decoded !== want.decoded)
                    begin
                        fail_count++;
                        report_field("is_decoded", want.decoded, is_decoded);
                    end
                    if (last_out !== want.last)
                    begin
                        fail_count++;
                        report_field("last_out", want.last, last_out);
                    end
                end
            end
            waiting_results = expected_units.size();
        end
    end

endmodule

FILE: tb/hex_escape_to_unicode_stream_tb.sv
`timescale 1ns / 100ps

module hex_escape_to_unicode_stream_tb;

    // No-progress limit: far above the long receiver hold-off plus a flush.
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 150;
    localparam int TARGET_BEATS = 330;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [heu_pkg::UNIT_W-1:0]  code_unit;
    logic                        last_unit;
    logic                        out_valid;
    logic                        out_stall;
    logic [heu_pkg::UNIT_W-1:0]  out_unit;
    logic                        is_decoded;
    logic                        last_out;

    int                 fail_count;
    int                 waiting_results;
    int                 units_in;
    int                 units_out;
    int                 decoded_out;

    int                 idle_cycles = 0;
    int                 beats_sent  = 0;
    int                 regions_sent = 0;
    int                 burst_left  = 0;

    // Text of the region being built, sent as one run ending in last_unit.
    logic [15:0]        region_text[$];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    hex_escape_to_unicode_stream dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_unit   (out_unit),
        .is_decoded (is_decoded),
        .last_out   (last_out)
    );

    hex_escape_stream_checker escape_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .code_unit       (code_unit),
        .last_unit       (last_unit),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_unit        (out_unit),
        .is_decoded      (is_decoded),
        .last_out        (last_out),
        .fail_count      (fail_count),
        .waiting_results (waiting_results),
        .units_in        (units_in),
        .units_out       (units_out),
        .decoded_out     (decoded_out)
    );

    // Watchdog: any accepted beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: picks a new stall mode for each run of random length. Once, in the
    // middle of the random traffic, it holds off for a long stretch while the
    // sender keeps offering, so the block backs up and stalls its input.
    initial
    begin
        int mode;
        int span;
        int tick;
        bit held_long;
        out_stall = 1'b0;
        tick      = 0;
        held_long = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (!held_long && beats_sent >= 140)
                begin
                    held_long = 1'b1;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;                          // free flowing
                        1: out_stall <= ($urandom_range(0, 3) == 0);   // light
                        2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy
                        default: out_stall <= ((tick % 3) == 0);       // periodic
                    endcase
                end
            end
        end
    end

    // One input beat. Valid stays up across a burst; after the burst a gap
    // of random length with junk on the payload lines.
    task automatic send_beat(input logic [15:0] cu, input logic lu);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        code_unit <= cu;
        last_unit <= lu;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid  <= 1'b0;
            code_unit <= 16'($urandom);
            last_unit <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
            // long bursts now and then give stretches with no idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Sends the region built so far, last_unit on its final unit.
    task automatic send_region();
        int i;
        for (i = 0; i < region_text.size(); i++)
            send_beat(region_text[i], i == region_text.size() - 1);
        region_text.delete();
        regions_sent++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            region_text.push_back({8'h00, s[i]});
    endtask

    // Hex digit of value v, letters in random case.
    function automatic logic [15:0] hex_char(input int v);
        if (v < 10)
            return 16'(16'h0030 + v);
        if ($urandom_range(0, 1))
            return 16'(16'h0041 + v - 10);
        return 16'(16'h0061 + v - 10);
    endfunction

    // Units just outside the digit ranges, and escape characters with
    // stray upper bits.
    function automatic logic [15:0] near_miss_char();
        case ($urandom_range(0, 9))
            0: return 16'h002F;
            1: return 16'h003A;
            2: return 16'h0040;
            3: return 16'h0047;
            4: return 16'h0060;
            5: return 16'h0067;
            6: return 16'h0130;
            7: return 16'h0155;
            8: return 16'h015C;
            default: return 16'h102B;
        endcase
    endfunction

    // Well-formed escape with random prefix and digits; a broken one has a
    // single unit replaced by a near miss.
    task automatic add_escape(input bit broken);
        logic [5:0][15:0] e;
        int               k;
        case ($urandom_range(0, 3))
            0:
            begin
                e[0] = heu_pkg::CHAR_UPPER_U;
                e[1] = heu_pkg::CHAR_PLUS;
            end
            1:
            begin
                e[0] = heu_pkg::CHAR_LOWER_U;
                e[1] = heu_pkg::CHAR_PLUS;
            end
            2:
            begin
                e[0] = heu_pkg::CHAR_BSLASH;
                e[1] = heu_pkg::CHAR_LOWER_U;
            end
            default:
            begin
                e[0] = heu_pkg::CHAR_BSLASH;
                e[1] = heu_pkg::CHAR_UPPER_U;
            end
        endcase
        for (k = 2; k < 6; k++)
            e[k] = hex_char($urandom_range(0, 15));
        if (broken)
            e[$urandom_range(0, 5)] = near_miss_char();
        for (k = 0; k < 6; k++)
            region_text.push_back(e[k]);
    endtask

    // Six tokens in ten are escapes; stray prefix characters make for
    // overlapping and leftmost cases when tokens run together.
    task automatic add_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: add_escape(1'b0);
            5: add_escape(1'b1);
            6: region_text.push_back(near_miss_char());
            7: region_text.push_back(16'($urandom));
            8: region_text.push_back(16'($urandom_range(16'h0020, 16'h007E)));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: region_text.push_back(heu_pkg::CHAR_UPPER_U);
                    1: region_text.push_back(heu_pkg::CHAR_LOWER_U);
                    2: region_text.push_back(heu_pkg::CHAR_BSLASH);
                    default: region_text.push_back(heu_pkg::CHAR_PLUS);
                endcase
            end
        endcase
    endtask

    initial
    begin
        int target;
        rst_n     = 1'b1;
        in_valid  = 1'b0;
        code_unit = '0;
        last_unit = 1'b0;
        // clean falling edge on reset ahead of the first clock
        #1;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: short region at the unit extremes
        region_text.push_back(16'hFFFF);
        region_text.push_back(16'h0000);
        send_region();
        // escape at the region start, then an escape completed by the last unit
        add_text("U+09aFu+7bE3");
        send_region();
        // full window and a non-digit on the last unit: all six units pass through
        add_text("\\UfFAg");
        send_region();
        add_text("\\u8000");
        send_region();

        // Random regions, mostly short, a few long; some cut mid-escape
        while (beats_sent < TARGET_BEATS)
        begin
            target = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 20);
            while (region_text.size() < target)
                add_token();
            if ($urandom_range(0, 1))
                while (region_text.size() > target)
                    void'(region_text.pop_back());
            send_region();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (waiting_results == 0);
        // room for any stray beat after the last expected one
        repeat (20) @(posedge clk);

        $display("Sent %0d units in %0d regions; got %0d result units, %0d decoded.",
                 units_in, regions_sent, units_out, decoded_out);
        $display("Receiver held off %0d cycles once while the sender kept offering.",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/heu_pkg.sv
rtl/heu_cell.sv
rtl/heu_match.sv
rtl/heu_outq.sv
rtl/hex_escape_to_unicode_stream.sv
rtl/heu_checker.sv
tb/hex_escape_stream_checker.sv
tb/hex_escape_to_unicode_stream_tb.sv
